### hw/rtl/swac_pkg.sv
// Shared types and constants for the shortest-window-all-colours unit.
// Holds the command beat, the result beat and the back-end state encoding.
// No dependencies.
package swac_pkg;

  localparam int COLOR_W = 11;
  localparam int OUT_W   = 17;

  // Best-length value before any full window has been seen.
  localparam logic [OUT_W-1:0] BEST_LEN_RESET = '1;

  localparam logic [COLOR_W-1:0] NUM_COLORS_RESET = COLOR_W'(1);

  typedef struct packed {
    logic               bad;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] best_start;
    logic [OUT_W-1:0] best_end;
    logic             found;
    logic             bad_item;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_HEADW,
    ST_HEADC
  } back_state_t;

endpackage

### hw/rtl/shortest_window_all_colors_unit.sv
// Top level of the shortest-window-all-colours unit.
// Depends on swac_pkg, swac_front, swac_fifo, swac_back (and swac_ram below it).
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-----------------------------------
//   config   | cfg_valid / cfg_ready       | cfg_data: num_colors, 11 bits
//   input    | push / full                 | color, 11 bits
//   result   | empty / pop                 | best_start, best_end, found, bad_item
//
// An ignored item is answered straight from ST_IDLE; a usable item
// steps through ST_INC, ST_HEADW and ST_HEADC, and repeats ST_HEADW and ST_HEADC for
// every item dropped from the window front, each position being dropped once at
// most. The walk is set by the count store, which has one read and one write port.
// Reset: the count store is swept to zero entry by entry; full stays
// high until then, while configuration writes are still taken.
// Stalls: a four-beat command queue and a two-beat result queue let input and
// output stall on their own; the back end waits only for a free result slot.
module shortest_window_all_colors_unit import swac_pkg::*; #(
  parameter int MAX_COLORS = 2048,
  parameter int MAX_LEN    = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COLOR_W-1:0] cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [COLOR_W-1:0] color,
  output logic               empty,
  input  logic               pop,
  output logic [OUT_W-1:0]   best_start,
  output logic [OUT_W-1:0]   best_end,
  output logic               found,
  output logic               bad_item
);

  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  logic               queue_full;
  logic               clearing;
  logic               cmd_push;
  cmd_t               cmd_in;
  cmd_t               cmd_out;
  logic               cmd_empty;
  logic               cmd_pop;
  logic [COLOR_W-1:0] num_colors;
  logic               res_full;
  logic               res_push;
  res_t               res_in;
  res_t               res_out;

  // Classify each accepted beat and hold the colour count register.
  swac_front #(.MAX_COLORS(MAX_COLORS), .MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .color     (color),
    .full      (full),
    .queue_full(queue_full),
    .clearing  (clearing),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .num_colors(num_colors)
  );

  // Decouple the front from the window walk.
  swac_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (queue_full),
    .pop  (cmd_pop),
    .rdata(cmd_out),
    .empty(cmd_empty)
  );

  // Advance the window and track the best full window.
  swac_back #(.MAX_COLORS(MAX_COLORS), .MAX_LEN(MAX_LEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .num_colors(num_colors),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_ready (!res_full),
    .res_push  (res_push),
    .res       (res_in),
    .clearing  (clearing)
  );

  // Hold finished results until the consumer pops them.
  swac_fifo #(.WIDTH($bits(res_t)), .DEPTH(RES_DEPTH)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign best_start = res_out.best_start;
  assign best_end   = res_out.best_end;
  assign found      = res_out.found;
  assign bad_item   = res_out.bad_item;

  a_no_input_while_clearing : assert property (@(posedge clk) disable iff (rst)
    clearing |-> full)
    else $error("input beat possible during the clearing pass");

  a_found_has_bounds : assert property (@(posedge clk) disable iff (rst)
    (!empty && found) |-> (best_start != '0) && (best_start <= best_end))
    else $error("found result carries an empty window");

  a_none_has_zero : assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (best_start == '0) && (best_end == '0))
    else $error("result without a window carries bounds");

endmodule

### hw/rtl/swac_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the colour count store and the window colour store. No dependencies.
module swac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/swac_fifo.sv
// Small register-based first-in first-out queue with full and empty flags.
// Used between front and back end and on the result side. No dependencies.
module swac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      level;
  logic             do_push;
  logic             do_pop;

  assign full    = (level == (AW+1)'(DEPTH));
  assign empty   = (level == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   level <= level + (AW+1)'(1);
        2'b01:   level <= level - (AW+1)'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

### hw/rtl/swac_front.sv
// Front end: holds the colour-count register, accepts input beats and
// classifies each as usable or ignored. Depends on swac_pkg.
module swac_front import swac_pkg::*; #(
  parameter int MAX_COLORS = 2048,
  parameter int MAX_LEN    = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COLOR_W-1:0] cfg_data,
  input  logic               push,
  input  logic [COLOR_W-1:0] color,
  output logic               full,
  input  logic               queue_full,
  input  logic               clearing,
  output logic               cmd_push,
  output cmd_t               cmd,
  output logic [COLOR_W-1:0] num_colors
);

  localparam int POS_W = ($clog2(MAX_LEN + 1) > OUT_W) ? $clog2(MAX_LEN + 1) : OUT_W;

  logic [POS_W-1:0] accepted;
  logic             bad;

  assign cfg_ready = 1'b1;
  assign full      = queue_full || clearing;
  assign cmd_push  = push && !full;

  // Ignore colour zero, colours above the configured count or the store,
  // and anything once the stream has reached its maximum length.
  assign bad = (color == '0) ||
               (color > num_colors) ||
               (32'(color) >= 32'(MAX_COLORS)) ||
               (32'(accepted) >= 32'(MAX_LEN));

  assign cmd.bad   = bad;
  assign cmd.color = color;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colors <= NUM_COLORS_RESET;
      accepted   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_colors <= cfg_data;
      end
      if (cmd_push && !bad) begin
        accepted <= accepted + POS_W'(1);
      end
    end
  end

endmodule

### hw/rtl/swac_back.sv
// Back end: runs the sliding window over the count and window stores,
// tracks the best full window and produces one result beat per command.
// Depends on swac_pkg and swac_ram.
module swac_back import swac_pkg::*; #(
  parameter int MAX_COLORS = 2048,
  parameter int MAX_LEN    = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COLOR_W-1:0] num_colors,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  input  logic               res_ready,
  output logic               res_push,
  output res_t               res,
  output logic               clearing
);

  localparam int POS_W  = ($clog2(MAX_LEN + 1) > OUT_W) ? $clog2(MAX_LEN + 1) : OUT_W;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int CIDX_W = $clog2(MAX_COLORS);
  localparam int DIST_W = CIDX_W + 1;
  localparam int WIN_AW = $clog2(MAX_LEN);

  back_state_t        state, state_next;
  logic [CIDX_W-1:0]  clear_idx, clear_idx_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [POS_W-1:0]   head0, head0_next;
  logic [DIST_W-1:0]  distinct, distinct_next;
  logic [POS_W-1:0]   best_first, best_first_next;
  logic [POS_W-1:0]   best_last, best_last_next;
  logic [POS_W-1:0]   best_length, best_length_next;
  logic               have_best, have_best_next;
  logic [COLOR_W-1:0] cur_color, cur_color_next;
  logic [POS_W-1:0]   size;

  logic               cnt_we, cnt_re;
  logic [CIDX_W-1:0]  cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic               win_we, win_re;
  logic [WIN_AW-1:0]  win_waddr, win_raddr;
  logic [COLOR_W-1:0] win_wdata, win_rdata;

  swac_ram #(.WIDTH(CNT_W), .DEPTH(MAX_COLORS)) u_counts (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .re   (cnt_re),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  swac_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_LEN)) u_window (
    .clk  (clk),
    .we   (win_we),
    .waddr(win_waddr),
    .wdata(win_wdata),
    .re   (win_re),
    .raddr(win_raddr),
    .rdata(win_rdata)
  );

  assign clearing = (state == ST_CLEAR);
  assign size     = pos - head0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clear_idx   <= '0;
      pos         <= '0;
      head0       <= '0;
      distinct    <= '0;
      best_first  <= '0;
      best_last   <= '0;
      best_length <= POS_W'(BEST_LEN_RESET);
      have_best   <= 1'b0;
    end else begin
      state       <= state_next;
      clear_idx   <= clear_idx_next;
      pos         <= pos_next;
      head0       <= head0_next;
      distinct    <= distinct_next;
      best_first  <= best_first_next;
      best_last   <= best_last_next;
      best_length <= best_length_next;
      have_best   <= have_best_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_color <= cur_color_next;
  end

  always_comb begin
    state_next       = state;
    clear_idx_next   = clear_idx;
    pos_next         = pos;
    head0_next       = head0;
    distinct_next    = distinct;
    best_first_next  = best_first;
    best_last_next   = best_last;
    best_length_next = best_length;
    have_best_next   = have_best;
    cur_color_next   = cur_color;
    cmd_pop          = 1'b0;
    res_push         = 1'b0;
    cnt_we           = 1'b0;
    cnt_waddr        = CIDX_W'(cur_color);
    cnt_wdata        = '0;
    cnt_re           = 1'b0;
    cnt_raddr        = CIDX_W'(win_rdata);
    win_we           = 1'b0;
    win_waddr        = WIN_AW'(pos);
    win_wdata        = cmd.color;
    win_re           = 1'b0;
    win_raddr        = WIN_AW'(head0);

    unique case (state)
      ST_CLEAR: begin
        // Sweep the count store to zero, one entry a cycle.
        cnt_we    = 1'b1;
        cnt_waddr = clear_idx;
        if (clear_idx == CIDX_W'(MAX_COLORS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clear_idx_next = clear_idx + CIDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid && res_ready) begin
          cmd_pop = 1'b1;
          if (cmd.bad) begin
            res_push = 1'b1;
          end else begin
            // Store the colour at the tail and fetch its count.
            win_we         = 1'b1;
            cnt_re         = 1'b1;
            cnt_raddr      = CIDX_W'(cmd.color);
            cur_color_next = cmd.color;
            state_next     = ST_INC;
          end
        end
      end
      ST_INC: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_rdata + CNT_W'(1);
        if (cnt_rdata == '0) begin
          distinct_next = distinct + DIST_W'(1);
        end
        pos_next   = pos + POS_W'(1);
        win_re     = 1'b1;
        state_next = ST_HEADW;
      end
      ST_HEADW: begin
        // Window front colour is out; fetch its count.
        cnt_re     = 1'b1;
        state_next = ST_HEADC;
      end
      ST_HEADC: begin
        if ((cnt_rdata > CNT_W'(1)) && (head0 < pos)) begin
          // Drop the front item: its colour occurs again later.
          cnt_we     = 1'b1;
          cnt_waddr  = CIDX_W'(win_rdata);
          cnt_wdata  = cnt_rdata - CNT_W'(1);
          head0_next = head0 + POS_W'(1);
          win_re     = 1'b1;
          win_raddr  = WIN_AW'(head0 + POS_W'(1));
          state_next = ST_HEADW;
        end else begin
          if ((32'(distinct) == 32'(num_colors)) && (size < best_length)) begin
            best_first_next  = head0 + POS_W'(1);
            best_last_next   = pos;
            best_length_next = size;
            have_best_next   = 1'b1;
          end
          res_push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign res.best_start = have_best_next ? OUT_W'(best_first_next) : '0;
  assign res.best_end   = have_best_next ? OUT_W'(best_last_next) : '0;
  assign res.found      = have_best_next;
  assign res.bad_item   = (state == ST_IDLE);

  a_clear_after_reset : assert property (@(posedge clk)
    rst |=> state == ST_CLEAR)
    else $error("back end did not restart its clearing pass");

  a_head_within_window : assert property (@(posedge clk) disable iff (rst)
    head0 <= pos)
    else $error("window front passed the tail");

  a_best_consistent : assert property (@(posedge clk) disable iff (rst)
    have_best |-> best_length == best_last - best_first + POS_W'(1))
    else $error("best window length disagrees with its bounds");

  a_no_pop_while_busy : assert property (@(posedge clk) disable iff (rst)
    (state == ST_INC || state == ST_HEADW) |-> !cmd_pop && !res_push)
    else $error("command taken or result sent mid-item");

endmodule

### verif/tb_shortest_window_all_colors_unit.sv
// Self-checking testbench for shortest_window_all_colors_unit.
// Depends on swac_pkg and the unit itself; predicts each result beat in-line
// and checks every beat popped from the result side.
module tb_shortest_window_all_colors_unit;
  import swac_pkg::*;

  localparam int MAX_COLORS  = 2048;
  localparam int MAX_LEN     = 65536;
  localparam int TRAIL_AW    = $clog2(MAX_LEN);
  // Slowest clean run is made up of: the colour-store sweep, ~1.65k beats through the
  // back end, idle gaps on both sides and one long receiver hold.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_SHOWN   = 40;
  localparam logic [COLOR_W-1:0] TOP_COLOR = '1;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COLOR_W-1:0] cfg_data  = '0;
  logic               push      = 1'b0;
  logic               full;
  logic [COLOR_W-1:0] color     = '0;
  logic               empty;
  logic               pop       = 1'b0;
  logic [OUT_W-1:0]   best_start;
  logic [OUT_W-1:0]   best_end;
  logic               found;
  logic               bad_item;

  shortest_window_all_colors_unit #(
    .MAX_COLORS(MAX_COLORS),
    .MAX_LEN   (MAX_LEN)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .color     (color),
    .empty     (empty),
    .pop       (pop),
    .best_start(best_start),
    .best_end  (best_end),
    .found     (found),
    .bad_item  (bad_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Window tracker: our own copy of the colour tallies, the stream of accepted
  // colours and the best window so far.
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0]   tally [0:MAX_COLORS-1];
  logic [COLOR_W-1:0] trail [0:MAX_LEN-1];
  logic [OUT_W-1:0]   front_pos    = OUT_W'(1);
  logic [OUT_W-1:0]   last_pos     = '0;
  logic [COLOR_W:0]   colours_seen = '0;
  logic [OUT_W-1:0]   win_first    = '0;
  logic [OUT_W-1:0]   win_last     = '0;
  logic [OUT_W-1:0]   win_len      = BEST_LEN_RESET;
  logic               win_valid    = 1'b0;
  logic [COLOR_W-1:0] want_colors  = NUM_COLORS_RESET;

  res_t best_window_q[$];      // predicted result beats, oldest first

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned ignored_cnt  = 0;
  int unsigned best_updates = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;

  logic               idle_on    = 1'b0;
  int unsigned        hold_asks  = 0;
  int unsigned        hold_seen  = 0;
  int unsigned        rx_gap     = 0;
  logic [COLOR_W-1:0] last_color = COLOR_W'(1);
  res_t               rx_want;

  // Advance the tracker by one colour and return the beat it should produce.
  function automatic res_t predict_best(input logic [COLOR_W-1:0] c);
    res_t r;
    logic skip;
    skip = (c == '0) || (c > want_colors) || (int'(c) >= MAX_COLORS) ||
           (last_pos >= OUT_W'(MAX_LEN));
    if (skip) begin
      ignored_cnt++;
    end else begin
      last_pos = last_pos + OUT_W'(1);
      trail[TRAIL_AW'(last_pos - OUT_W'(1))] = c;
      if (tally[c] == '0) colours_seen = colours_seen + (COLOR_W+1)'(1);
      tally[c] = tally[c] + OUT_W'(1);
      // Drop front entries whose colour still occurs further back.
      while (front_pos <= last_pos &&
             tally[trail[TRAIL_AW'(front_pos - OUT_W'(1))]] > OUT_W'(1)) begin
        tally[trail[TRAIL_AW'(front_pos - OUT_W'(1))]] =
          tally[trail[TRAIL_AW'(front_pos - OUT_W'(1))]] - OUT_W'(1);
        front_pos = front_pos + OUT_W'(1);
      end
      if (colours_seen == {1'b0, want_colors} &&
          (last_pos - front_pos + OUT_W'(1)) < win_len) begin
        win_first = front_pos;
        win_last  = last_pos;
        win_len   = last_pos - front_pos + OUT_W'(1);
        win_valid = 1'b1;
        best_updates++;
      end
    end
    r.best_start = win_valid ? win_first : '0;
    r.best_end   = win_valid ? win_last : '0;
    r.found      = win_valid;
    r.bad_item   = skip;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: check each popped beat, then decide pop for the next edge.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t: %s wrong, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (best_window_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: result beat with none expected, expected nothing, actual %0d/%0d/%b/%b",
                   $time, best_start, best_end, found, bad_item);
      end else begin
        rx_want = best_window_q[0];
        best_window_q.delete(0);
        compare_field("best_start", rx_want.best_start, best_start);
        compare_field("best_end", rx_want.best_end, best_end);
        compare_field("found", OUT_W'(rx_want.found), OUT_W'(found));
        compare_field("bad_item", OUT_W'(rx_want.bad_item), OUT_W'(bad_item));
      end
    end
    // A fresh hold request wins; otherwise finish any gap, or maybe start one.
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      rx_gap    <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      pop    <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 7);
      pop    <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt,
               best_window_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers. Each is entered in the time step of a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one colour and hold it until taken; push stays high on return.
  task automatic send_color(input logic [COLOR_W-1:0] c);
    res_t want;
    push  <= 1'b1;
    color <= c;
    do @(posedge clk); while (full);
    want = predict_best(c);
    best_window_q.insert(best_window_q.size(), want);
    items_sent++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic tx_gap();
    if (idle_on && $urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 8));
  endtask

  // Stop offering and hold until every predicted beat has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    while (best_window_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_num_colors(input logic [COLOR_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    want_colors = v;
  endtask

  // Mostly colours from 1..hi with runs of repeats, plus zero and
  // out-of-range colours as noise.
  function automatic logic [COLOR_W-1:0] rand_color(input int unsigned hi);
    int unsigned r;
    logic [COLOR_W-1:0] pick;
    r = $urandom_range(0, 99);
    if (r < 5)
      pick = '0;
    else if (r < 10 && want_colors < TOP_COLOR)
      pick = COLOR_W'($urandom_range(int'(want_colors) + 1, int'(TOP_COLOR)));
    else if (r < 30)
      pick = last_color;
    else
      pick = COLOR_W'($urandom_range(1, hi));
    last_color = pick;
    return pick;
  endfunction

  task automatic send_random(input int unsigned n, input int unsigned hi);
    repeat (n) begin
      tx_gap();
      send_color(rand_color(hi));
    end
  endtask

  // A run of consecutive colours; long runs pull the window down towards hi.
  task automatic send_sweep(input int unsigned hi);
    int unsigned start;
    int unsigned len;
    start = $urandom_range(0, hi - 1);
    len   = $urandom_range(hi / 2, hi);
    for (int unsigned k = 0; k < len; k++) begin
      tx_gap();
      send_color(COLOR_W'((start + k) % hi + 1));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset value of num_colors is 1; send nothing valid so no window forms yet.
  task automatic test_reset_defaults();
    send_color('0);
    send_color(COLOR_W'(2));
    send_color(TOP_COLOR);
    send_color(COLOR_W'('h555));
  endtask

  // With zero colours wanted every colour is out of range.
  task automatic test_zero_colors();
    write_num_colors('0);
    send_color(COLOR_W'(1));
    send_color(COLOR_W'('h2aa));
    send_color(TOP_COLOR);
  endtask

  task automatic test_single_color();
    write_num_colors(COLOR_W'(1));
    send_color(COLOR_W'(3));
    send_color(COLOR_W'('h400));
  endtask

  // Widest setting: only zero is rejected; a repeat drops the older copy.
  task automatic test_max_colors();
    write_num_colors(TOP_COLOR);
    send_color('0);
    send_color(COLOR_W'(1));
    send_color(COLOR_W'(1));
  endtask

  // Collect colours 1..30 while far more are wanted, so nothing completes.
  task automatic test_grow_under_wide();
    idle_on <= 1'b1;
    send_random(150, 30);
  endtask

  // Narrow the setting mid-stream: the tallies carry over and windows start
  // completing at once, then keep shrinking.
  task automatic test_switch_to_full();
    write_num_colors(COLOR_W'(30));
    repeat (20) begin
      send_random(14, 30);
      send_sweep(30);
    end
  endtask

  // Receiver holds off for a long stretch while beats keep coming.
  task automatic test_receiver_hold();
    hold_asks <= hold_asks + 1;
    repeat (60) send_color(rand_color(30));
  endtask

  task automatic test_sender_pause();
    send_random(50, 30);
    wait_drained();
    send_random(50, 30);
  endtask

  task automatic test_wider_set();
    write_num_colors(COLOR_W'(45));
    send_random(300, 45);
  endtask

  task automatic test_steady_stream();
    idle_on <= 1'b0;
    send_random(300, 45);
  endtask

  initial begin
    for (int i = 0; i < MAX_COLORS; i++) tally[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_colors();
    test_single_color();
    test_max_colors();
    test_grow_under_wide();
    test_switch_to_full();
    test_receiver_hold();
    test_sender_pause();
    test_wider_set();
    test_steady_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d colour beats (%0d ignored), %0d results, %0d best-window updates",
             items_sent, ignored_cnt, results_seen, best_updates);
    $display("settings 0, 1, 30, 45 and 2047, long receiver hold, sender pause to empty");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
